// ===== src/alol_pkg.sv =====
// Shared types and constants of the ordered array list engine.
// Holds the request and response word structs, operation and status codes.
// No dependencies; imported by alol_ctrl and the top level file.
`default_nettype none

package alol_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int POS_W           = 9;
    localparam int CAP_W           = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        FN_GET    = 2'd0,
        FN_FIND   = 2'd1,
        FN_INSERT = 2'd2,
        FN_REMOVE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [POS_W-1:0]   position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] data;
        logic [7:0]         found_index;
        logic [8:0]         length;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/alol_mem.sv =====
// Element store of the ordered array list engine: one write and one read port.
// Read data is registered. Depends on nothing but its parameters.
`default_nettype none

module alol_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/alol_ctrl.sv =====
// Sequencer of the ordered array list engine: checks requests, walks the
// element store one entry per cycle and builds the response word.
// Depends on alol_pkg; drives the ports of alol_mem.
`default_nettype none

module alol_ctrl
    import alol_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int ADDR_W      = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire req_t                  req,
    input  wire logic [CAP_W-1:0]      capacity,
    output logic                       res_valid,
    output rsp_t                       res,
    input  wire logic                  res_take,
    output logic                       mem_we,
    output logic [ADDR_W-1:0]          mem_waddr,
    output logic [DATA_WIDTH-1:0]      mem_wdata,
    output logic                       mem_re,
    output logic [ADDR_W-1:0]          mem_raddr,
    input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

    localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GET  = 6'b000010,
        S_FIND = 6'b000100,
        S_INS  = 6'b001000,
        S_REM  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    pend_reg, pend_next;
    logic [CMP_W-1:0]        cnt_reg, cnt_next;
    logic [CMP_W-1:0]        pos_reg, pos_next;
    logic [ADDR_W-1:0]       wa_reg, wa_next;
    logic [DATA_WIDTH-1:0]   word_reg, word_next;
    status_t                 status_reg, status_next;
    logic [31:0]             data_reg, data_next;
    logic [7:0]              found_reg, found_next;

    logic [CMP_W-1:0]        len_c, pos_in, cap_c, eff_cap, cnt_dec, cnt_inc;
    logic signed [EXT_W-1:0] vext, dext;

    assign len_c   = CMP_W'(len_reg);
    assign pos_in  = CMP_W'(req.position);
    assign cap_c   = CMP_W'(capacity);
    assign eff_cap = (cap_c > MAX_C) ? MAX_C : cap_c;
    assign cnt_dec = cnt_reg - CMP_W'(1);
    assign cnt_inc = cnt_reg + CMP_W'(1);
    assign vext    = EXT_W'(req.value);
    assign dext    = EXT_W'(signed'(mem_rdata));

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        wa_next     = wa_reg;
        word_next   = word_reg;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = wa_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    word_next   = vext[DATA_WIDTH-1:0];
                    pos_next    = pos_in;
                    status_next = ST_OK;
                    data_next   = '0;
                    found_next  = '0;
                    pend_next   = 1'b0;
                    unique case (req.func)
                        FN_GET:
                        begin
                            if (pos_in >= len_c)
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_in[ADDR_W-1:0];
                                state_next = S_GET;
                            end
                        end
                        FN_FIND:
                        begin
                            status_next = ST_NOTFOUND;
                            cnt_next    = '0;
                            state_next  = S_FIND;
                        end
                        FN_INSERT:
                        begin
                            if (len_c >= eff_cap)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else if (pos_in > len_c)
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                cnt_next   = len_c;
                                state_next = S_INS;
                            end
                        end
                        FN_REMOVE:
                        begin
                            if (len_c == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else if (pos_in >= len_c)
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                cnt_next   = pos_in;
                                state_next = S_REM;
                            end
                        end
                    endcase
                end
            end
            S_GET:
            begin
                data_next  = dext[31:0];
                state_next = S_DONE;
            end
            S_FIND:
            begin
                if (pend_reg && (mem_rdata == word_reg))
                begin
                    status_next = ST_OK;
                    found_next  = 8'(wa_reg);
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                end
                else if (cnt_reg < len_c)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg[ADDR_W-1:0];
                    wa_next   = cnt_reg[ADDR_W-1:0];
                    pend_next = 1'b1;
                    cnt_next  = cnt_inc;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_INS:
            begin
                mem_we = pend_reg;
                if (cnt_reg > pos_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_dec[ADDR_W-1:0];
                    wa_next   = cnt_reg[ADDR_W-1:0];
                    pend_next = 1'b1;
                    cnt_next  = cnt_dec;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[ADDR_W-1:0];
                    mem_wdata  = word_reg;
                    len_next   = len_reg + LEN_W'(1);
                    state_next = S_DONE;
                end
            end
            S_REM:
            begin
                mem_we = pend_reg;
                if (cnt_inc < len_c)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_inc[ADDR_W-1:0];
                    wa_next   = cnt_reg[ADDR_W-1:0];
                    pend_next = 1'b1;
                    cnt_next  = cnt_inc;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    len_next   = len_reg - LEN_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        pos_reg    <= pos_next;
        wa_reg     <= wa_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.data        = data_reg;
    assign res.found_index = found_reg;
    assign res.length      = 9'(len_reg);

endmodule

`default_nettype wire

// ===== src/ordered_array_list_engine.sv =====
// Ordered array list engine, top level: capacity register, response register,
// sequencer and element store. Depends on alol_pkg, alol_ctrl and alol_mem.
//
// Usage:
//   Requests enter on req (valid/ready); each request word names get, find,
//   insert or remove. One response word leaves on rsp (valid/ready) per request.
//   The capacity register is written through cfg_we/cfg_data; the user must
//   write it only while idle, which the block itself does not enforce.
// Timing:
//   A rejected request goes straight to the done state; get reads one entry;
//   find, insert and remove walk the list: the sequencer moves one element per
//   cycle through the single read and single write port of the element store.
//   One request is in work at a time; req_ready is high only while idle.
// Reset:
//   The list is empty and capacity is 256; store contents are left as is.
// Stall:
//   A finished response waits in the response register while the next
//   request is accepted; a second finished response waits in the sequencer.
`default_nettype none

module ordered_array_list_engine
    import alol_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire req_t             req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output rsp_t                  rsp,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_data
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [CAP_W-1:0]      cap_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;
    logic                  res_valid;
    rsp_t                  res;
    logic                  out_free;
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign out_free = !rsp_valid_reg || rsp_ready;

    alol_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DATA_WIDTH  (DATA_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .capacity  (cap_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (out_free),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    alol_mem #(
        .DEPTH  (MAX_ENTRIES),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (res_valid && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a request is in work");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_free |=> res_valid && $stable(res))
        else $error("finished result lost while response register is busy");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.data == '0) && (rsp.found_index == '0))
        else $error("failed request carries data");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.length) <= 32'(MAX_ENTRIES)))
        else $error("list length beyond store depth");
`endif

endmodule

`default_nettype wire
